// ===== hdl/crc8ce_pkg.sv =====
// Package for the configurable CRC-8 engine.
// Holds field widths, configuration register indexes and the configuration struct.
// No dependencies.
package crc8ce_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLY       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECTED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] POLY_RESET       = 8'h07;
  localparam logic              REFLECTED_RESET  = 1'b0;
  localparam logic [BYTE_W-1:0] INIT_VALUE_RESET = 8'h00;
  localparam logic [BYTE_W-1:0] FINAL_XOR_RESET  = 8'h00;
  localparam logic [BYTE_W-1:0] CRC_RESET        = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] poly;
    logic              reflected;
    logic [BYTE_W-1:0] init_value;
    logic [BYTE_W-1:0] final_xor;
  } cfg_t;

endpackage

// ===== hdl/crc8ce_in_if.sv =====
// Request channel carrying message bytes into the CRC-8 engine.
// Depends on crc8ce_pkg for the byte width.
interface crc8ce_in_if;
  import crc8ce_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

// ===== hdl/crc8ce_out_if.sv =====
// Result channel carrying check values out of the CRC-8 engine.
// Depends on crc8ce_pkg for the byte width.
interface crc8ce_out_if;
  import crc8ce_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] check_value;

  modport source (output valid, output check_value, input ready);
  modport sink   (input valid, input check_value, output ready);
endinterface

// ===== hdl/crc8ce_cfg.sv =====
// Configuration register bank of the CRC-8 engine.
// Decodes the write port into poly, reflected, init_value and final_xor.
// Depends on crc8ce_pkg.
module crc8ce_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [crc8ce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crc8ce_pkg::CFG_DATA_W-1:0] cfg_data,
  output crc8ce_pkg::cfg_t                 cfg
);
  import crc8ce_pkg::*;

  // register writes, decoded by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poly       <= POLY_RESET;
      cfg.reflected  <= REFLECTED_RESET;
      cfg.init_value <= INIT_VALUE_RESET;
      cfg.final_xor  <= FINAL_XOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLY:       cfg.poly       <= cfg_data[BYTE_W-1:0];
        REG_REFLECTED:  cfg.reflected  <= cfg_data[0];
        REG_INIT_VALUE: cfg.init_value <= cfg_data[BYTE_W-1:0];
        REG_FINAL_XOR:  cfg.final_xor  <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/crc8ce_fold.sv =====
// Byte fold of the CRC-8 engine: seed select, byte XOR and eight unrolled bit steps.
// Purely combinational. Depends on crc8ce_pkg.
module crc8ce_fold (
  input  logic [crc8ce_pkg::BYTE_W-1:0] crc,
  input  logic [crc8ce_pkg::BYTE_W-1:0] data_byte,
  input  logic                          first_byte,
  input  crc8ce_pkg::cfg_t              cfg,
  output logic [crc8ce_pkg::BYTE_W-1:0] folded
);
  import crc8ce_pkg::*;

  logic [BYTE_W-1:0] rpoly;
  logic [BYTE_W-1:0] acc;

  // bit-reversed polynomial for the right-shifting form
  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      rpoly[i] = cfg.poly[BYTE_W-1-i];
    end
  end

  // eight shift/XOR steps, direction chosen by the reflected flag
  always_comb begin
    acc = (first_byte ? cfg.init_value : crc) ^ data_byte;
    for (int s = 0; s < BYTE_W; s++) begin
      if (cfg.reflected) begin
        acc = acc[0] ? ((acc >> 1) ^ rpoly) : (acc >> 1);
      end else begin
        acc = acc[BYTE_W-1] ? ((acc << 1) ^ cfg.poly) : (acc << 1);
      end
    end
    folded = acc;
  end

endmodule

// ===== hdl/crc8_configurable_engine_core.sv =====
// Top level of the configurable CRC-8 engine.
// Holds the input register, CRC register and result register; uses crc8ce_cfg and crc8ce_fold.
// Depends on crc8ce_pkg, crc8ce_in_if and crc8ce_out_if.
//
// Byte-serial CRC-8 with programmable polynomial, bit order, initial value and final XOR.
// One byte is accepted per clock cycle while the pipe is not held back. A request lands in
// the input register and is then folded into the CRC register by eight unrolled
// shift/XOR steps; a byte marked last places its check value in the result register at
// that same edge, so check_value passes the input register and then the result register.
// Only the single result register can hold the pipe back: when it is full and not
// being drained, a last byte waits in the input register; bytes without the last mark
// keep flowing. first_byte reloads init_value, otherwise the CRC continues from the
// previous value (zero after reset). Write configuration only while the engine is empty.
module crc8_configurable_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  crc8ce_in_if.sink                         msg,
  crc8ce_out_if.source                      chk,
  input  logic                              cfg_we,
  input  logic [crc8ce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crc8ce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crc8ce_pkg::*;

  cfg_t              cfg;
  logic              in_valid;
  logic [BYTE_W-1:0] in_data;
  logic              in_first;
  logic              in_last;
  logic [BYTE_W-1:0] crc;
  logic [BYTE_W-1:0] folded;
  logic              out_valid;
  logic [BYTE_W-1:0] out_value;
  logic              advance;

  crc8ce_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crc8ce_fold u_fold (
    .crc        (crc),
    .data_byte  (in_data),
    .first_byte (in_first),
    .cfg        (cfg),
    .folded     (folded)
  );

  // held byte moves on unless it needs the result register and that is still full
  assign advance   = in_valid && (!in_last || !out_valid || chk.ready);
  assign msg.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg.ready) begin
      in_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready && msg.valid) begin
      in_data  <= msg.data_byte;
      in_first <= msg.first_byte;
      in_last  <= msg.last_byte;
    end
  end

  // CRC register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_RESET;
    end else if (advance) begin
      crc <= folded;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (chk.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_value <= folded ^ cfg.final_xor;
    end
  end

  assign chk.valid       = out_valid;
  assign chk.check_value = out_value;

endmodule
